[rtl/ssr_pkg.sv]
// Package for the stream substring replace block.
// Register indexes, sizes and the byte select helper; no dependencies.
`timescale 1ns / 1ps

package ssr_pkg;

   localparam int unsigned MaxStringBytes = 8;
   localparam int unsigned WordBits       = 8 * MaxStringBytes;
   localparam int unsigned LenBits        = 4;
   localparam int unsigned AddrBits       = 5;

   localparam logic [1:0] RegPatternBytes     = 2'd0;
   localparam logic [1:0] RegPatternLength    = 2'd1;
   localparam logic [1:0] RegReplacementBytes = 2'd2;
   localparam logic [1:0] RegReplacementLength = 2'd3;

   typedef logic [WordBits-1:0] word_type;
   typedef logic [LenBits-1:0]  len_type;

   function automatic logic [7:0] byte_at(input word_type word, input logic [2:0] sel);
      byte_at = word[8*sel +: 8];
   endfunction

endpackage

[rtl/stream_substring_replace.sv]
// Stream substring replace, top level.
// Uses ssr_pkg for register indexes, widths and the byte select helper.
`timescale 1ns / 1ps

// Usage:
//   req_* : input stream, one byte per item, tlast marks end of stream.
//   rsp_* : output stream, tlast marks the last byte caused by one input item.
//   csr_* : APB-style register port, 64-bit data, register i at byte address 8*i
//           (pattern, pattern length, replacement, replacement length).
// Each input item is matched against the pattern byte at the held prefix length.
// A mismatch emits the held prefix and the byte; a full match emits the
// replacement and drops the following replacement length minus one bytes.
// Timing: an item is accepted, then decided in the S_DECIDE state; its 0..8
// result bytes leave one per cycle, when rsp_tready allows, through a single
// output register; the block takes the next item once the last result byte is
// loaded.
// A stalled rsp_tready holds the output register and the sequencer.
// Reset clears the match and skip counts and restores register defaults.
module stream_substring_replace (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ssr_pkg::AddrBits-1:0]  csr_paddr,
   input  logic [63:0]                   csr_pwdata,
   output logic [63:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;

   logic [1:0]             state_ff, state_in;
   ssr_pkg::word_type      pattern_ff, replacement_ff;
   ssr_pkg::len_type       plen_reg_ff, rlen_reg_ff;
   ssr_pkg::len_type       match_ff, match_in;
   ssr_pkg::len_type       skip_ff, skip_in;
   logic [7:0]             data_ff;
   logic                   eos_ff;
   ssr_pkg::len_type       count_ff, count_in;
   logic                   append_ff, append_in;
   logic                   repl_ff, repl_in;
   ssr_pkg::len_type       idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;

   ssr_pkg::len_type       plen, rlen, match_sat, match_next, total;
   logic                   csr_write, load;
   ssr_pkg::word_type      src_word;
   logic [7:0]             sel_byte;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_paddr[4:3])
         ssr_pkg::RegPatternBytes:     csr_prdata = pattern_ff;
         ssr_pkg::RegPatternLength:    csr_prdata = {60'd0, plen_reg_ff};
         ssr_pkg::RegReplacementBytes: csr_prdata = replacement_ff;
         default:                      csr_prdata = {60'd0, rlen_reg_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         plen_reg_ff    <= 4'd1;
         replacement_ff <= '0;
         rlen_reg_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[4:3])
            ssr_pkg::RegPatternBytes:     pattern_ff     <= csr_pwdata;
            ssr_pkg::RegPatternLength:    plen_reg_ff    <= csr_pwdata[3:0];
            ssr_pkg::RegReplacementBytes: replacement_ff <= csr_pwdata;
            default:                      rlen_reg_ff    <= csr_pwdata[3:0];
         endcase
      end
   end

   // effective lengths
   always_comb begin
      if (plen_reg_ff == 4'd0)
         plen = 4'd1;
      else if (plen_reg_ff > 4'(ssr_pkg::MaxStringBytes))
         plen = 4'(ssr_pkg::MaxStringBytes);
      else
         plen = plen_reg_ff;
      rlen = (rlen_reg_ff > 4'(ssr_pkg::MaxStringBytes)) ?
             4'(ssr_pkg::MaxStringBytes) : rlen_reg_ff;
      match_sat  = (match_ff > plen - 4'd1) ? plen - 4'd1 : match_ff;
      match_next = match_sat + 4'd1;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign total      = count_ff + {3'd0, append_ff};
   assign load       = (state_ff == S_EMIT) && (!out_valid_ff || rsp_tready);

   // shared byte selector for the emitted pattern and replacement bytes
   assign src_word = repl_ff ? replacement_ff : pattern_ff;
   assign sel_byte = ssr_pkg::byte_at(src_word, idx_ff[2:0]);

   always_comb begin
      state_in     = state_ff;
      match_in     = match_ff;
      skip_in      = skip_ff;
      count_in     = count_ff;
      append_in    = append_ff;
      repl_in      = repl_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            count_in  = '0;
            append_in = 1'b0;
            repl_in   = 1'b0;
            idx_in    = '0;
            match_in  = match_sat;
            if (skip_ff != 4'd0) begin
               skip_in = skip_ff - 4'd1;
            end else if (data_ff != ssr_pkg::byte_at(pattern_ff, match_sat[2:0])) begin
               count_in  = match_sat;
               append_in = 1'b1;
               match_in  = '0;
            end else if (match_next == plen) begin
               count_in = rlen;
               repl_in  = 1'b1;
               skip_in  = (rlen != 4'd0) ? rlen - 4'd1 : 4'd0;
               match_in = '0;
            end else begin
               match_in = match_next;
            end
            if (eos_ff) begin
               if (match_in != 4'd0) begin
                  count_in = match_in;
                  repl_in  = 1'b0;
               end
               match_in = '0;
               skip_in  = '0;
            end
            state_in = ((count_in + {3'd0, append_in}) == 4'd0) ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (load) begin
               out_valid_in = 1'b1;
               out_byte_in  = (idx_ff < count_ff) ? sel_byte : data_ff;
               out_last_in  = (idx_ff + 4'd1 == total);
               idx_in       = idx_ff + 4'd1;
               if (idx_ff + 4'd1 == total) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         match_ff     <= '0;
         skip_ff      <= '0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         append_ff    <= 1'b0;
         repl_ff      <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         match_ff     <= match_in;
         skip_ff      <= skip_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         append_ff    <= append_in;
         repl_ff      <= repl_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
         eos_ff  <= req_tlast;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
